[hdl/rc4_pkg.sv]
`timescale 1ns / 1ps

package rc4_pkg;

   // Permutation geometry.
   localparam int PERM_SIZE = 256;
   localparam int ADDR_W    = $clog2(PERM_SIZE);
   localparam int BYTE_W    = 8;

   // Key storage.
   localparam int MAX_KEY_BYTES = 32;
   localparam int KEY_LEN_W     = 6;
   localparam int KEY_POS_W     = $clog2(MAX_KEY_BYTES);
   localparam int KEY_REG_W     = 64;
   localparam int KEY_REG_CNT   = MAX_KEY_BYTES / (KEY_REG_W / BYTE_W);
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_0_7    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_8_15   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_16_23  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_24_31  = 3'd4;

   // Command codes.
   localparam logic CMD_REKEY = 1'b0;
   localparam logic CMD_CRYPT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KS_CLEAR,
      ST_KS_READ_K,
      ST_KS_READ_J,
      ST_KS_WRITE_K,
      ST_KS_WRITE_J,
      ST_CR_READ_I,
      ST_CR_READ_J,
      ST_CR_WRITE_I,
      ST_CR_WRITE_J
   } state_type;

   // One access to the permutation memory.
   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
   } ram_req_type;

endpackage

[hdl/rc4_if.sv]
`timescale 1ns / 1ps

interface rc4_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_in;

   modport source (output valid, output command, output data_in, input ready);
   modport sink (input valid, input command, input data_in, output ready);
endinterface

interface rc4_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;

   modport source (output valid, output data_out, input ready);
   modport sink (input valid, input data_out, output ready);
endinterface

interface rc4_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/rc4_add_unit.sv]
`timescale 1ns / 1ps

module rc4_add_unit
   import rc4_pkg::*;
(
   input  logic [BYTE_W-1:0] op_a,
   input  logic [BYTE_W-1:0] op_b,
   input  logic [BYTE_W-1:0] op_c,
   output logic [BYTE_W-1:0] sum
);

   // The i, j and k arithmetic of the cipher is modulo 256, so the carry is dropped.
   assign sum = BYTE_W'(op_a + op_b + op_c);

endmodule

[hdl/rc4_sbox_ram.sv]
`timescale 1ns / 1ps

module rc4_sbox_ram
   import rc4_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ram_req_type       req,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0]    mem_ff [PERM_SIZE];
   logic [PERM_SIZE-1:0] valid_ff;
   logic [BYTE_W-1:0]    rd_data_ff;

   // An entry that has not been written since the last clear holds its own index.
   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_addr] <= req.wr_data;
      end
   end

   // Write-first: a read of the address being written returns the new byte.
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
            rd_data_ff <= req.wr_data;
         end else if (valid_ff[req.rd_addr]) begin
            rd_data_ff <= mem_ff[req.rd_addr];
         end else begin
            rd_data_ff <= req.rd_addr;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/rc4_stream_cipher_top.sv]
`timescale 1ns / 1ps

// RC4 stream cipher engine. A transaction on the request channel carries a command and a
// data byte. A rekey command (command 0) runs the key schedule over the key held in the
// configuration registers and gives no response; it keeps the engine busy until it ends.
// The permutation memory does at most one read and one write per cycle, so each swap of
// the schedule is done in steps: fetch the partner slot, write the slot, then write the
// partner while the next slot is read. The schedule starts by clearing the permutation
// and reading its first slot. A crypt command (command 1) keeps the engine busy while it
// reads S[i], reads S[j], then writes both slots of the swap, the second write also
// loading the response register. That write repeats while the previous response has not
// been taken. The engine then returns to idle, where it takes the next request. The XOR
// of the data byte with the keystream byte appears as one response transaction.
// Encryption and decryption are the same command. After reset the permutation is the
// identity and both indices are zero, so crypt works before any rekey. The request
// channel is ready only while the engine is idle; the response register lets a new
// request in while a result still waits. Configuration writes (key length at index 0,
// key bytes at indexes 1 to 4, little-endian) are always accepted and must only be
// issued while the engine is idle. A key length of zero acts as one, and lengths above
// 32 act as 32.

module rc4_stream_cipher_top
   import rc4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rc4_req_if.sink     req_bus,
   rc4_rsp_if.source   rsp_bus,
   rc4_csr_if.sink     csr_bus
);

   // Configuration registers.
   logic [KEY_LEN_W-1:0] key_length_ff;
   logic [KEY_REG_W-1:0] key_ff [KEY_REG_CNT];

   // Sequencer and datapath registers.
   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    i_ff, i_in;
   logic [ADDR_W-1:0]    j_ff, j_in;
   logic [ADDR_W-1:0]    k_ff, k_in;
   logic [KEY_POS_W-1:0] kpos_ff, kpos_in;
   logic [BYTE_W-1:0]    sa_ff, sa_in;
   logic                 hit_j_ff, hit_j_in;
   logic [BYTE_W-1:0]    din_ff, din_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_data_ff, rsp_data_in;

   ram_req_type          ram_req;
   logic [BYTE_W-1:0]    ram_rd_data;

   logic [BYTE_W-1:0]    add_a, add_b, add_c, add_sum;

   logic [KEY_LEN_W-1:0] eff_len;
   logic [KEY_LEN_W-1:0] kpos_next;
   logic [BYTE_W-1:0]    key_byte;
   logic                 req_fire;
   logic                 out_free;

   rc4_sbox_ram u_sbox_ram (
      .clock   (clock),
      .reset   (reset),
      .req     (ram_req),
      .rd_data (ram_rd_data)
   );

   // The one adder serves every update of i, j and k in both the key schedule and the generator.
   rc4_add_unit u_add_unit (
      .op_a (add_a),
      .op_b (add_b),
      .op_c (add_c),
      .sum  (add_sum)
   );

   // Configuration writes. Indexes beyond the register list are ignored.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= KEY_LEN_RESET;
         for (int n = 0; n < KEY_REG_CNT; n++) begin
            key_ff[n] <= '0;
         end
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_KEY_LENGTH: key_length_ff <= csr_bus.data[KEY_LEN_W-1:0];
            CSR_KEY_0_7:    key_ff[0] <= csr_bus.data;
            CSR_KEY_8_15:   key_ff[1] <= csr_bus.data;
            CSR_KEY_16_23:  key_ff[2] <= csr_bus.data;
            CSR_KEY_24_31:  key_ff[3] <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // The key length in use, clamped to the range 1 to 32.
   always_comb begin
      if (key_length_ff == '0) begin
         eff_len = KEY_LEN_W'(1);
      end else if (key_length_ff > KEY_LEN_W'(MAX_KEY_BYTES)) begin
         eff_len = KEY_LEN_W'(MAX_KEY_BYTES);
      end else begin
         eff_len = key_length_ff;
      end
   end

   assign key_byte  = key_ff[kpos_ff[KEY_POS_W-1:3]][{kpos_ff[2:0], 3'b000} +: BYTE_W];
   assign kpos_next = {1'b0, kpos_ff} + KEY_LEN_W'(1);

   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign req_fire         = req_bus.valid && req_bus.ready;
   assign out_free         = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.data_out = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         kpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         kpos_ff      <= kpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff       <= sa_in;
      hit_j_ff    <= hit_j_in;
      din_ff      <= din_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      kpos_in      = kpos_ff;
      sa_in        = sa_ff;
      hit_j_in     = hit_j_ff;
      din_in       = din_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      ram_req      = '0;
      add_a        = '0;
      add_b        = '0;
      add_c        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               din_in = req_bus.data_in;
               if (req_bus.command == CMD_CRYPT) begin
                  state_in = ST_CR_READ_I;
               end else begin
                  state_in = ST_KS_CLEAR;
               end
            end
         end

         // Key schedule: the permutation returns to identity by dropping all valid bits.
         ST_KS_CLEAR: begin
            ram_req.clear = 1'b1;
            k_in          = '0;
            j_in          = '0;
            kpos_in       = '0;
            state_in      = ST_KS_READ_K;
         end

         ST_KS_READ_K: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = k_ff;
            state_in        = ST_KS_READ_J;
         end

         // j = j + S[k] + key[kpos], then fetch S[j].
         ST_KS_READ_J: begin
            add_a           = j_ff;
            add_b           = ram_rd_data;
            add_c           = key_byte;
            j_in            = add_sum;
            sa_in           = ram_rd_data;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = add_sum;
            state_in        = ST_KS_WRITE_K;
         end

         ST_KS_WRITE_K: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = k_ff;
            ram_req.wr_data = ram_rd_data;
            state_in        = ST_KS_WRITE_J;
         end

         // Finish the swap and prefetch S[k+1]; the memory forwards the byte being written.
         ST_KS_WRITE_J: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = j_ff;
            ram_req.wr_data = sa_ff;
            if (k_ff == ADDR_W'(PERM_SIZE - 1)) begin
               i_in     = '0;
               j_in     = '0;
               state_in = ST_IDLE;
            end else begin
               add_a           = k_ff;
               add_b           = BYTE_W'(1);
               k_in            = add_sum;
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = add_sum;
               if (kpos_next >= eff_len) begin
                  kpos_in = '0;
               end else begin
                  kpos_in = kpos_next[KEY_POS_W-1:0];
               end
               state_in = ST_KS_READ_J;
            end
         end

         // Generator: i = i + 1, fetch S[i].
         ST_CR_READ_I: begin
            add_a           = i_ff;
            add_b           = BYTE_W'(1);
            i_in            = add_sum;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = add_sum;
            state_in        = ST_CR_READ_J;
         end

         // j = j + S[i], fetch S[j].
         ST_CR_READ_J: begin
            add_a           = j_ff;
            add_b           = ram_rd_data;
            j_in            = add_sum;
            sa_in           = ram_rd_data;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = add_sum;
            state_in        = ST_CR_WRITE_I;
         end

         // S[i] takes S[j], and the keystream slot S[i]+S[j] is read in the same cycle.
         // The write to S[j] follows in ST_CR_WRITE_J, so a slot equal to j is taken from S[i].
         ST_CR_WRITE_I: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = i_ff;
            ram_req.wr_data = ram_rd_data;
            add_a           = sa_ff;
            add_b           = ram_rd_data;
            hit_j_in        = (add_sum == j_ff);
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = add_sum;
            state_in        = ST_CR_WRITE_J;
         end

         ST_CR_WRITE_J: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = j_ff;
            ram_req.wr_data = sa_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = din_ff ^ (hit_j_ff ? sa_ff : ram_rd_data);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A response only ever comes out of the final generator step.
   a_rsp_from_crypt: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_CR_WRITE_J)
      else $error("response raised outside the generator step");

   // The key schedule leaves both indices cleared.
   a_ks_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KS_WRITE_J && k_ff == ADDR_W'(PERM_SIZE - 1))
      |=> (state_ff == ST_IDLE && i_ff == '0 && j_ff == '0))
      else $error("key schedule ended with nonzero indices");

   // The key position never reaches the key length in use.
   a_kpos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KS_READ_J) |-> ({1'b0, kpos_ff} < eff_len))
      else $error("key position beyond key length");

   // A held response is never overwritten by a new one.
   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending response overwritten");

endmodule
